@@ rtl/pkx_pkg.sv @@
// Shared types, constants and functions of the lagged-generator keystream block.
// No dependencies; used by every other file of the block.
package pkx_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned NUM_GEN       = 3;
    localparam int unsigned STORE_DEPTH   = 64;
    localparam int unsigned FILL_STEPS    = 8;    // lfsr shifts per fill cycle
    localparam int unsigned FILL_SUBSTEPS = WORD_W / FILL_STEPS;
    localparam int unsigned SUB_W         = $clog2(FILL_SUBSTEPS);
    localparam int unsigned FILL_CNT_W    = $clog2(STORE_DEPTH * FILL_SUBSTEPS);
    localparam int unsigned APB_ADDR_W    = 3;

    localparam int unsigned LAG_A [NUM_GEN] = '{55, 57, 58};
    localparam int unsigned LAG_B [NUM_GEN] = '{24, 7, 19};

    localparam logic [WORD_W-1:0] SEED_MIX  = 32'h0502_7919;
    localparam logic [WORD_W-1:0] MASK_ODD  = 32'hAAAA_AAAA;
    localparam logic [WORD_W-1:0] MASK_EVEN = 32'h5555_5555;
    localparam logic [WORD_W-1:0] MASK_HI   = 32'hF0F0_F0F0;
    localparam logic [WORD_W-1:0] MASK_LO   = 32'h0F0F_0F0F;

    localparam logic [2:0] USED_EMPTY = 3'd4;

    localparam logic CMD_XOR     = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [APB_ADDR_W-1:0] ADDR_SEED = 3'd0;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic load;   // load lfsr with generator seed, clear carry
        logic fill;   // advance lfsr
        logic push;   // shift lfsr word into the store
        logic step;   // generator step
    } gen_ctrl_t;

    function automatic word_t lfsr_shift(input word_t v);
        logic fb;
        fb = v[31] ^ v[6] ^ v[4] ^ v[2] ^ v[1] ^ v[0];
        return {fb, v[WORD_W-1:1]};
    endfunction

    function automatic word_t lfsr_multi(input word_t v);
        word_t t;
        t = v;
        for (int i = 0; i < FILL_STEPS; i++) begin
            t = lfsr_shift(t);
        end
        return t;
    endfunction

    function automatic word_t gen_seed(input int idx, input word_t s);
        word_t r;
        case (idx)
            0:       r = s;
            1:       r = ((s & MASK_ODD) >> 1) | ((s & MASK_EVEN) << 1);
            default: r = ~(((s & MASK_HI) >> 4) | ((s & MASK_LO) << 4));
        endcase
        return lfsr_shift(r);
    endfunction

endpackage

@@ rtl/pkx_cell.sv @@
// One word of a generator's lag line; loads its input word (the neighbor's word, or the new head word) when enabled.
// Depends on pkx_pkg.
module pkx_cell (
    input  logic          aclk,
    input  logic          en,
    input  pkx_pkg::word_t d,
    output pkx_pkg::word_t q
);

    pkx_pkg::word_t q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/pkx_gen.sv @@
// One lagged additive generator: a chain of pkx_cell words, tap adder, carry flag
// and the seeding lfsr. Depends on pkx_pkg and pkx_cell.
module pkx_gen #(
    parameter int unsigned LAG_A = pkx_pkg::LAG_A[0],
    parameter int unsigned LAG_B = pkx_pkg::LAG_B[0]
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pkx_pkg::gen_ctrl_t ctrl,
    input  pkx_pkg::word_t     seed_in,
    output pkx_pkg::word_t     newest,
    output pkx_pkg::word_t     stepped,
    output logic               carry
);

    // tap[k] holds the word k steps older than the newest one
    pkx_pkg::word_t tap [pkx_pkg::STORE_DEPTH];
    pkx_pkg::word_t lfsr_reg;
    pkx_pkg::word_t lfsr_next;
    pkx_pkg::word_t head;
    logic [pkx_pkg::WORD_W:0] sum;
    logic carry_reg;
    logic shift_en;

    assign lfsr_next = pkx_pkg::lfsr_multi(lfsr_reg);
    assign sum       = {1'b0, tap[LAG_A-1]} + {1'b0, tap[LAG_B-1]};
    assign head      = ctrl.fill ? lfsr_next : sum[pkx_pkg::WORD_W-1:0];
    assign shift_en  = ctrl.push | ctrl.step;

    for (genvar k = 0; k < pkx_pkg::STORE_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            pkx_cell u_cell (.aclk(aclk), .en(shift_en), .d(head), .q(tap[k]));
        end else begin : g_body
            pkx_cell u_cell (.aclk(aclk), .en(shift_en), .d(tap[k-1]), .q(tap[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            lfsr_reg <= seed_in;
        end else if (ctrl.fill) begin
            lfsr_reg <= lfsr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= 1'b0;
        end else if (ctrl.load) begin
            carry_reg <= 1'b0;
        end else if (ctrl.step) begin
            carry_reg <= sum[pkx_pkg::WORD_W];
        end
    end

    assign newest  = tap[0];
    assign stepped = sum[pkx_pkg::WORD_W-1:0];
    assign carry   = carry_reg;

endmodule

@@ rtl/pike_keystream_xor.sv @@
// Byte stream cipher from three lagged additive generators (lags 55/24, 57/7,
// 58/19) with majority clocking on their carry flags. A data transfer (tuser 0)
// returns one byte per cycle while the output is taken; a generator step happens
// in the same cycle as every fourth byte. A restart transfer (tuser 1), and reset,
// reseed the 64-word lag lines from the seed register through an lfsr advanced
// 8 bits per cycle: a load cycle, then fill cycles that push the lfsr words in,
// during which s_tready stays low and no output is produced. Depends on pkx_pkg, pkx_gen.
module pike_keystream_xor (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_in
    input  logic                             s_tuser,   // [0] cmd
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] data_out
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pkx_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int unsigned NG = pkx_pkg::NUM_GEN;

    pkx_pkg::word_t                       seed_reg;
    logic                                 pending_reg;
    logic                                 busy_reg;
    logic [pkx_pkg::FILL_CNT_W-1:0]       fill_cnt_reg;
    logic [2:0]                           used_reg;
    pkx_pkg::word_t                       word_reg;
    logic                                 m_tvalid_reg;
    logic [pkx_pkg::BYTE_W-1:0]           m_tdata_reg;

    pkx_pkg::gen_ctrl_t ctrl     [NG];
    pkx_pkg::word_t     gseed    [NG];
    pkx_pkg::word_t     newest   [NG];
    pkx_pkg::word_t     stepped  [NG];
    pkx_pkg::word_t     after    [NG];
    logic [NG-1:0]      carry;
    logic [NG-1:0]      take;
    logic               maj;
    logic               data_go;
    logic               restart_go;
    logic               need_word;
    logic               push;
    pkx_pkg::word_t     seed_mix;
    pkx_pkg::word_t     word_next;
    logic [pkx_pkg::BYTE_W-1:0] ks_byte;

    assign s_tready   = !pending_reg && !busy_reg && (!m_tvalid_reg || m_tready);
    assign data_go    = s_tvalid && s_tready && (s_tuser == pkx_pkg::CMD_XOR);
    assign restart_go = s_tvalid && s_tready && (s_tuser == pkx_pkg::CMD_RESTART);
    assign need_word  = used_reg[2];
    assign push       = busy_reg && (fill_cnt_reg[pkx_pkg::SUB_W-1:0] == '1);
    assign seed_mix   = seed_reg ^ pkx_pkg::SEED_MIX;

    assign maj = (carry[0] & carry[1]) | (carry[0] & carry[2]) | (carry[1] & carry[2]);

    for (genvar g = 0; g < NG; g++) begin : g_gen
        assign gseed[g]     = pkx_pkg::gen_seed(g, seed_mix);
        assign take[g]      = (carry[g] == maj);
        assign ctrl[g].load = pending_reg;
        assign ctrl[g].fill = busy_reg;
        assign ctrl[g].push = push;
        assign ctrl[g].step = data_go && need_word && take[g];
        assign after[g]     = take[g] ? stepped[g] : newest[g];

        pkx_gen #(
            .LAG_A(pkx_pkg::LAG_A[g]),
            .LAG_B(pkx_pkg::LAG_B[g])
        ) u_gen (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl[g]),
            .seed_in (gseed[g]),
            .newest  (newest[g]),
            .stepped (stepped[g]),
            .carry   (carry[g])
        );
    end

    assign word_next = after[0] ^ after[1] ^ after[2];
    assign ks_byte   = need_word ? word_next[pkx_pkg::BYTE_W-1:0]
                                 : word_reg[pkx_pkg::BYTE_W*used_reg[1:0] +: pkx_pkg::BYTE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg     <= '0;
            pending_reg  <= 1'b1;
            busy_reg     <= 1'b0;
            fill_cnt_reg <= '0;
            used_reg     <= pkx_pkg::USED_EMPTY;
            word_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && (paddr == pkx_pkg::ADDR_SEED)) begin
                seed_reg <= pwdata;
            end

            pending_reg <= restart_go;

            if (pending_reg) begin
                busy_reg     <= 1'b1;
                fill_cnt_reg <= '0;
            end else if (busy_reg) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                end
            end

            if (pending_reg) begin
                used_reg <= pkx_pkg::USED_EMPTY;
                word_reg <= '0;
            end else if (data_go) begin
                if (need_word) begin
                    used_reg <= 3'd1;
                    word_reg <= word_next;
                end else begin
                    used_reg <= used_reg + 3'd1;
                end
            end

            if (data_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (data_go) begin
            m_tdata_reg <= s_tdata ^ ks_byte;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == pkx_pkg::ADDR_SEED) ? seed_reg : '0;

endmodule

@@ rtl/pkx_checker.sv @@
// Port-level checks of pike_keystream_xor, attached by bind.
// Depends on pkx_pkg.
module pkx_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [7:0]                     m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // data transfer always yields a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pkx_pkg::CMD_XOR) |=> m_tvalid)
        else $error("data transfer without result");

    // restart yields no result and blocks input as reseeding begins
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pkx_pkg::CMD_RESTART) |=> !m_tvalid && !s_tready)
        else $error("restart produced a result or accepted input");

    // input is closed when reset is released, as the reseed begins
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready)
        else $error("input accepted before reseed after reset");

endmodule

bind pike_keystream_xor pkx_checker u_pkx_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for pike_keystream_xor: byte transfers and restarts on the stream
// side, seed writes over APB, every output byte checked against an in-bench cipher model.
// Depends on rtl/pkx_pkg.sv and rtl/pike_keystream_xor.sv.
`timescale 1ns / 100ps

module tb_top;

    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 3;
    localparam int          SETTLE       = 300;   // covers a full restart pass
    localparam int          STALL_LIMIT  = 4000;
    localparam int          PHASE_ITEMS  = 300;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [31:0] TAP_MASK     = 32'h8000_0057;   // bits 31, 6, 4, 2, 1, 0

    localparam logic [pkx_pkg::APB_ADDR_W-1:0] ADDR_SPARE = 3'd4;

    localparam int unsigned TAP_FAR  [3] = '{55, 57, 58};
    localparam int unsigned TAP_NEAR [3] = '{24, 7, 19};

    typedef enum logic [1:0] {
        ROW_DATA,
        ROW_RESTART,
        ROW_SEED,
        ROW_SPARE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] val;
    } stim_row_t;

    localparam int DIR_ROWS = 25;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_DATA,    32'h00},
        '{ROW_DATA,    32'hFF},
        '{ROW_DATA,    32'hA5},
        '{ROW_DATA,    32'h5A},
        '{ROW_DATA,    32'h01},
        '{ROW_DATA,    32'h80},
        '{ROW_RESTART, 32'h00},
        '{ROW_DATA,    32'h00},
        '{ROW_DATA,    32'hFF},
        '{ROW_SEED,    32'hFFFF_FFFF},
        '{ROW_RESTART, 32'hFF},
        '{ROW_DATA,    32'h3C},
        '{ROW_DATA,    32'hC3},
        '{ROW_DATA,    32'h00},
        '{ROW_DATA,    32'hFF},
        '{ROW_DATA,    32'h96},
        '{ROW_SPARE,   32'h1234_5678},
        '{ROW_RESTART, 32'h00},
        '{ROW_DATA,    32'hFF},
        '{ROW_SEED,    32'h0502_7919},
        '{ROW_RESTART, 32'h00},
        '{ROW_RESTART, 32'hFF},
        '{ROW_DATA,    32'h00},
        '{ROW_DATA,    32'h55},
        '{ROW_SEED,    32'h0000_0000}
    };

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata  = '0;      // [7:0] data_in
    logic                              s_tuser  = 1'b0;    // [0] cmd
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [7:0]                        m_tdata;            // [7:0] data_out
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [pkx_pkg::APB_ADDR_W-1:0]    paddr    = '0;
    logic [31:0]                       pwdata   = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    pike_keystream_xor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // cipher model state
    logic [31:0] lag_mem [3][64];
    logic [5:0]  lag_head [3];
    logic        lag_carry [3];
    logic [31:0] ks_word;
    logic [2:0]  ks_used;
    logic [31:0] seed_q;

    logic [7:0]  cipher_q [$];

    int mismatches   = 0;
    int n_bytes      = 0;
    int n_restarts   = 0;
    int n_seeds      = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;

    function automatic logic [31:0] lfsr_next(logic [31:0] v);
        return {^(v & TAP_MASK), v[31:1]};
    endfunction

    function void reseed_lags();
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] g [3];
        s    = seed_q ^ pkx_pkg::SEED_MIX;
        g[0] = lfsr_next(s);
        g[1] = lfsr_next(((s & pkx_pkg::MASK_ODD) >> 1) | ((s & pkx_pkg::MASK_EVEN) << 1));
        g[2] = lfsr_next(~(((s & pkx_pkg::MASK_HI) >> 4) | ((s & pkx_pkg::MASK_LO) << 4)));
        for (int gi = 0; gi < 3; gi++) begin
            t = g[gi];
            for (int e = 0; e < 64; e++) begin
                for (int k = 0; k < 32; k++) begin
                    t = lfsr_next(t);
                end
                lag_mem[gi][e] = t;
            end
            lag_carry[gi] = 1'b0;
            lag_head[gi]  = 6'd63;
        end
        ks_word = '0;
        ks_used = 3'd4;
    endfunction

    function void clock_lag(int gi);
        logic [5:0]  p;
        logic [5:0]  ia;
        logic [5:0]  ib;
        logic [32:0] sum;
        p   = lag_head[gi] + 6'd1;
        ia  = p - 6'(TAP_FAR[gi]);
        ib  = p - 6'(TAP_NEAR[gi]);
        sum = {1'b0, lag_mem[gi][ia]} + {1'b0, lag_mem[gi][ib]};
        lag_mem[gi][p] = sum[31:0];
        lag_carry[gi]  = sum[32];
        lag_head[gi]   = p;
    endfunction

    function void next_key_word();
        int   n;
        logic major;
        logic take [3];
        n     = int'(lag_carry[0]) + int'(lag_carry[1]) + int'(lag_carry[2]);
        major = (n == 2);
        for (int gi = 0; gi < 3; gi++) begin
            take[gi] = (n == 0) || (n == 3) || (lag_carry[gi] == major);
        end
        for (int gi = 0; gi < 3; gi++) begin
            if (take[gi]) begin
                clock_lag(gi);
            end
        end
        ks_word = lag_mem[0][lag_head[0]] ^ lag_mem[1][lag_head[1]] ^ lag_mem[2][lag_head[2]];
    endfunction

    function logic [7:0] next_key_byte();
        logic [7:0] kb;
        if (ks_used >= 3'd4) begin
            next_key_word();
            ks_used = 3'd0;
        end
        kb      = 8'(ks_word >> (8 * int'(ks_used)));
        ks_used = ks_used + 3'd1;
        return kb;
    endfunction

    // prediction on input transfers, checking on output transfers
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tuser == pkx_pkg::CMD_RESTART) begin
                reseed_lags();
                n_restarts++;
            end else begin
                cipher_q.push_back(s_tdata ^ next_key_byte());
                n_bytes++;
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (cipher_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected output byte %02h", m_tdata);
            end else if (m_tdata !== cipher_q[0]) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: data_out expected %02h got %02h", cipher_q[0], m_tdata);
                void'(cipher_q.pop_front());
            end else begin
                void'(cipher_q.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_item(logic cmd, logic [7:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic reg_write(logic [pkx_pkg::APB_ADDR_W-1:0] addr, logic [31:0] data);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == pkx_pkg::ADDR_SEED) begin
            seed_q = data;
            n_seeds++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == pkx_pkg::ADDR_SEED) begin
            @(negedge aclk);
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            got = prdata;
            if (got !== seed_q) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: seed readback expected %08h got %08h", seed_q, got);
            end
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    initial begin
        int          pick;
        logic [31:0] rseed;

        seed_q = '0;
        reseed_lags();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].kind)
                ROW_DATA: begin
                    send_item(pkx_pkg::CMD_XOR, dir_rows[r].val[7:0]);
                end
                ROW_RESTART: begin
                    send_item(pkx_pkg::CMD_RESTART, dir_rows[r].val[7:0]);
                end
                ROW_SEED: begin
                    settle_idle();
                    reg_write(pkx_pkg::ADDR_SEED, dir_rows[r].val);
                end
                default: begin
                    settle_idle();
                    reg_write(ADDR_SPARE, dir_rows[r].val);
                end
            endcase
        end

        for (int ph = 0; ph < 4; ph++) begin
            settle_idle();
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 84; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 6;  stall_pct = 6;  end
            endcase
            reg_write(pkx_pkg::ADDR_SEED, $urandom);
            send_item(pkx_pkg::CMD_RESTART, 8'($urandom_range(255)));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(99);
                if (pick == 0) begin
                    settle_idle();
                    case ($urandom_range(3))
                        0:       rseed = '0;
                        1:       rseed = '1;
                        default: rseed = $urandom;
                    endcase
                    reg_write(pkx_pkg::ADDR_SEED, rseed);
                end
                if (pick < 3)
                    send_item(pkx_pkg::CMD_RESTART, 8'($urandom_range(255)));
                else
                    send_item(pkx_pkg::CMD_XOR, 8'($urandom_range(255)));
            end
        end

        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (cipher_q.size() != 0) begin
            mismatches += cipher_q.size();
            $display("ERROR: %0d output bytes never arrived", cipher_q.size());
        end

        $display("Covered %0d data bytes and %0d restarts under %0d seed values,",
                 n_bytes, n_restarts, n_seeds);
        $display("with free-running, sender-gapped, receiver-stalled and mixed pacing.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pkx_pkg.sv
rtl/pkx_cell.sv
rtl/pkx_gen.sv
rtl/pike_keystream_xor.sv
rtl/pkx_checker.sv
dv/tb_top.sv
